/* rtl/core/apf_pkg.sv */
`default_nettype none

package apf_pkg;

  // Field and register widths
  localparam int SAMPLE_BITS   = 24;
  localparam int CHAN_BITS     = 3;
  localparam int COEF_BITS     = 23;
  localparam int GAIN_BITS     = 24;
  localparam int CFG_DATA_BITS = 24;
  localparam int CFG_IDX_BITS  = 2;
  localparam int DELAY_BITS    = 32;
  localparam int CHANNELS_DEF  = 8;

  // Fixed-point scaling
  localparam int COEF_FRAC  = 22;
  localparam int GAIN_SHIFT = 20;

  // Digit-serial multiplier geometry
  localparam int MUL_A_BITS = 34;
  localparam int MUL_B_BITS = 32;
  localparam int MUL_DIGIT  = 8;
  localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;

  // Internal datapath widths
  localparam int ACC_BITS = 58;
  localparam int K_BITS   = COEF_BITS + 2;
  localparam int R_BITS   = 40;
  localparam int Y_BITS   = R_BITS + 1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_COEF_C  = 2'd0,
    CFG_COEF_D  = 2'd1,
    CFG_GAIN_H0 = 2'd2
  } apf_cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WAIT,
    ST_XN,
    ST_AP,
    ST_OUT
  } apf_state_e;

  typedef enum logic [2:0] {
    PH_K,
    PH_P1,
    PH_P2,
    PH_P3,
    PH_P4
  } apf_phase_e;

  typedef struct packed {
    logic [CHAN_BITS-1:0]          chan;
    logic signed [SAMPLE_BITS-1:0] sample_in;
  } apf_in_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0]          chan_out;
    logic signed [SAMPLE_BITS-1:0] sample_out;
  } apf_out_t;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] coef_c;
    logic signed [COEF_BITS-1:0] coef_d;
    logic signed [GAIN_BITS-1:0] gain_h0;
  } apf_cfg_t;

  typedef struct packed {
    logic                         start;
    logic signed [MUL_A_BITS-1:0] a;
    logic signed [MUL_B_BITS-1:0] b;
  } apf_mul_req_t;

endpackage

`default_nettype wire

/* rtl/core/apf_serial_mul.sv */
`default_nettype none

module apf_serial_mul
  import apf_pkg::*;
(
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire apf_mul_req_t                 req_i,
  output logic                              done_o,
  output logic signed [MUL_P_BITS-1:0]      prod_o
);

  localparam int NDIG  = MUL_B_BITS / MUL_DIGIT;
  localparam int CNT_W = $clog2(NDIG + 1);
  localparam int PP_W  = MUL_A_BITS + MUL_DIGIT + 1;

  logic                         busy_q, busy_d;
  logic                         first_q, first_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic signed [MUL_A_BITS-1:0] a_q, a_d;
  logic [MUL_B_BITS-1:0]        b_q, b_d;
  logic signed [MUL_P_BITS-1:0] acc_q, acc_d;
  logic [MUL_DIGIT-1:0]         digit;
  logic signed [MUL_DIGIT:0]    digit_ext;
  logic signed [PP_W-1:0]       pp;
  logic                         step;

  // Top digit first: signed on the first step, unsigned after
  assign digit     = b_q[MUL_B_BITS-1 -: MUL_DIGIT];
  assign digit_ext = first_q ? $signed({digit[MUL_DIGIT-1], digit})
                             : $signed({1'b0, digit});
  assign pp        = a_q * digit_ext;
  assign step      = busy_q && (cnt_q != '0);

  assign done_o = busy_q && (cnt_q == '0);
  assign prod_o = acc_q;

  // Horner accumulation, one digit per cycle
  always_comb begin
    busy_d  = busy_q;
    first_d = first_q;
    cnt_d   = cnt_q;
    a_d     = a_q;
    b_d     = b_q;
    acc_d   = acc_q;
    if (req_i.start) begin
      busy_d  = 1'b1;
      first_d = 1'b1;
      cnt_d   = CNT_W'(NDIG);
      a_d     = req_i.a;
      b_d     = req_i.b;
      acc_d   = '0;
    end else if (step) begin
      first_d = 1'b0;
      cnt_d   = cnt_q - CNT_W'(1);
      b_d     = b_q << MUL_DIGIT;
      acc_d   = (acc_q <<< MUL_DIGIT) + MUL_P_BITS'(pp);
    end else if (done_o) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    a_q     <= a_d;
    b_q     <= b_d;
    acc_q   <= acc_d;
  end

endmodule

`default_nettype wire

/* rtl/core/apf_delay_mem.sv */
`default_nettype none

module apf_delay_mem
  import apf_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF,
  parameter int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         rd_en_i,
  input  wire logic [IDX_W-1:0]             rd_addr_i,
  output logic signed [DELAY_BITS-1:0]      rd_one_o,
  output logic signed [DELAY_BITS-1:0]      rd_two_o,
  input  wire logic                         wr_en_i,
  input  wire logic [IDX_W-1:0]             wr_addr_i,
  input  wire logic signed [DELAY_BITS-1:0] wr_one_i,
  input  wire logic signed [DELAY_BITS-1:0] wr_two_i
);

  localparam int WORD_W = 2 * DELAY_BITS;

  logic [WORD_W-1:0]   mem_q [CHANNELS];
  logic [CHANNELS-1:0] valid_q;
  logic [WORD_W-1:0]   rd_q;

  // Mark entries as written; unwritten entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  // Both delay words of a channel share one entry
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= {wr_one_i, wr_two_i};
    end
  end

  // Registered read, held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= valid_q[rd_addr_i] ? mem_q[rd_addr_i] : '0;
    end
  end

  assign rd_one_o = $signed(rd_q[WORD_W-1:DELAY_BITS]);
  assign rd_two_o = $signed(rd_q[DELAY_BITS-1:0]);

endmodule

`default_nettype wire

/* rtl/core/apf_core.sv */
`default_nettype none

module apf_core
  import apf_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire apf_cfg_t cfg_i,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire apf_in_t  in_item_i,
  output logic          res_valid_o,
  input  wire logic     res_ready_i,
  output apf_out_t      res_item_o
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  apf_state_e state_q, state_d;
  apf_phase_e phase_q, phase_d;

  logic [CHAN_BITS-1:0]          ch_q;
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic                          inrange_q;
  logic signed [K_BITS-1:0]      k_q;
  logic signed [ACC_BITS-1:0]    p1_q;
  logic signed [ACC_BITS-1:0]    s_q;
  logic signed [DELAY_BITS-1:0]  xn_q;
  logic signed [DELAY_BITS-1:0]  ap_q;
  logic signed [R_BITS-1:0]      r_q;

  logic                          accept;
  logic                          inrange_now;
  apf_mul_req_t                  mul_req;
  logic                          mul_done;
  logic signed [MUL_P_BITS-1:0]  mul_prod;
  logic signed [MUL_P_BITS-1:0]  prod_rnd;
  logic signed [ACC_BITS-1:0]    k_full;
  logic signed [DELAY_BITS-1:0]  s_sat;
  logic signed [Y_BITS-1:0]      y_full;
  logic signed [K_BITS-1:0]      omc;
  logic                          mem_wr_en;
  logic signed [DELAY_BITS-1:0]  xh0;
  logic signed [DELAY_BITS-1:0]  xh1;

  // Round half up at the coefficient point
  function automatic logic signed [ACC_BITS-1:0] rnd_coef(
    input logic signed [ACC_BITS-1:0] v
  );
    logic signed [ACC_BITS-1:0] t;
    t = v + $signed(ACC_BITS'(1) << (COEF_FRAC - 1));
    return t >>> COEF_FRAC;
  endfunction

  // Clamp to the delay word range
  function automatic logic signed [DELAY_BITS-1:0] sat_delay(
    input logic signed [ACC_BITS-1:0] v
  );
    logic fits;
    fits = (v[ACC_BITS-1:DELAY_BITS-1] == {(ACC_BITS-DELAY_BITS+1){v[ACC_BITS-1]}});
    if (fits) return v[DELAY_BITS-1:0];
    return v[ACC_BITS-1] ? $signed({1'b1, {(DELAY_BITS-1){1'b0}}})
                         : $signed({1'b0, {(DELAY_BITS-1){1'b1}}});
  endfunction

  // Clamp to the sample range
  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [Y_BITS-1:0] v
  );
    logic fits;
    fits = (v[Y_BITS-1:SAMPLE_BITS-1] == {(Y_BITS-SAMPLE_BITS+1){v[Y_BITS-1]}});
    if (fits) return v[SAMPLE_BITS-1:0];
    return v[Y_BITS-1] ? $signed({1'b1, {(SAMPLE_BITS-1){1'b0}}})
                       : $signed({1'b0, {(SAMPLE_BITS-1){1'b1}}});
  endfunction

  assign accept      = in_valid_i && in_ready_o;
  assign inrange_now = (32'(in_item_i.chan) < 32'(CHANNELS));

  // 1 - c, exact in Q2.22
  assign omc = $signed(K_BITS'(1) << COEF_FRAC) - K_BITS'(cfg_i.coef_c);

  assign k_full   = rnd_coef(ACC_BITS'(mul_prod));
  assign prod_rnd = (mul_prod + $signed(MUL_P_BITS'(1) << (GAIN_SHIFT - 1))) >>> GAIN_SHIFT;
  assign s_sat    = sat_delay(rnd_coef(s_q));
  assign y_full   = Y_BITS'(x_q) + Y_BITS'(r_q);

  apf_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  apf_delay_mem #(
    .CHANNELS (CHANNELS),
    .IDX_W    (IDX_W)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept && inrange_now),
    .rd_addr_i (IDX_W'(in_item_i.chan)),
    .rd_one_o  (xh0),
    .rd_two_o  (xh1),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (IDX_W'(ch_q)),
    .wr_one_i  (xn_q),
    .wr_two_i  (xh0)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = inrange_now ? ST_LOAD : ST_OUT;
          phase_d = PH_K;
        end
      end
      ST_LOAD: state_d = ST_WAIT;
      ST_WAIT: begin
        if (mul_done) begin
          unique case (phase_q)
            PH_K: begin
              state_d = ST_LOAD;
              phase_d = PH_P1;
            end
            PH_P1: begin
              state_d = ST_LOAD;
              phase_d = PH_P2;
            end
            PH_P2:   state_d = ST_XN;
            PH_P3:   state_d = ST_AP;
            PH_P4:   state_d = ST_OUT;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_XN: begin
        state_d = ST_LOAD;
        phase_d = PH_P3;
      end
      ST_AP: begin
        state_d = ST_LOAD;
        phase_d = PH_P4;
      end
      ST_OUT: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and multiplier operands
  always_comb begin
    in_ready_o    = (state_q == ST_IDLE);
    res_valid_o   = (state_q == ST_OUT);
    mem_wr_en     = (state_q == ST_LOAD) && (phase_q == PH_P3);
    mul_req.start = (state_q == ST_LOAD);
    unique case (phase_q)
      PH_K: begin
        mul_req.a = MUL_A_BITS'(omc);
        mul_req.b = MUL_B_BITS'(cfg_i.coef_d);
      end
      PH_P1: begin
        mul_req.a = MUL_A_BITS'(xh0);
        mul_req.b = MUL_B_BITS'(k_q);
      end
      PH_P2: begin
        mul_req.a = MUL_A_BITS'(xh1);
        mul_req.b = MUL_B_BITS'(cfg_i.coef_c);
      end
      PH_P3: begin
        mul_req.a = MUL_A_BITS'(xn_q);
        mul_req.b = MUL_B_BITS'(cfg_i.coef_c);
      end
      PH_P4: begin
        mul_req.a = MUL_A_BITS'(x_q) - MUL_A_BITS'(ap_q);
        mul_req.b = MUL_B_BITS'(cfg_i.gain_h0);
      end
      default: begin
        mul_req.a = '0;
        mul_req.b = '0;
      end
    endcase
    res_item_o.chan_out   = ch_q;
    res_item_o.sample_out = inrange_q ? sat_sample(y_full) : x_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_K;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  // Capture the item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q      <= in_item_i.chan;
      x_q       <= in_item_i.sample_in;
      inrange_q <= inrange_now;
    end
  end

  // Fold each finished product into k, the running sums or r; latch the clamped delay words
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_WAIT) && mul_done) begin
      unique case (phase_q)
        PH_K:  k_q <= k_full[K_BITS-1:0];
        PH_P1: begin
          p1_q <= ACC_BITS'(mul_prod);
          s_q  <= (ACC_BITS'(x_q) <<< COEF_FRAC) - ACC_BITS'(mul_prod);
        end
        PH_P2: s_q <= s_q + ACC_BITS'(mul_prod);
        PH_P3: s_q <= p1_q + (ACC_BITS'(xh1) <<< COEF_FRAC) - ACC_BITS'(mul_prod);
        PH_P4: r_q <= prod_rnd[R_BITS-1:0];
        default: ;
      endcase
    end
    if (state_q == ST_XN) xn_q <= s_sat;
    if (state_q == ST_AP) ap_q <= s_sat;
  end

`ifndef SYNTHESIS
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_WAIT))
    else $error("multiplier finished outside the wait state");

  a_wr_inrange: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_wr_en |-> inrange_q)
    else $error("delay write for a channel out of range");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_LOAD) || (state_q == ST_OUT))
    else $error("accepted item did not start processing");

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o && $stable(res_item_o))
    else $error("result changed while stalled");
`endif

endmodule

`default_nettype wire

/* rtl/core/allpass_peak_filter.sv */
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   in_item_i   (chan, sample_in)
// out       output     out_valid_o / out_ready_i out_item_o  (chan_out, sample_out)
// cfg       input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// For an item on a valid channel, five products pass in turn through one 8-bit
// digit-serial multiplier, four digit steps each, with load, rounding and handoff
// states between them; the next item is accepted only once the result is handed on.
// An item whose channel is out of range passes through unchanged.
// Reset clears the coefficients and marks every channel's delay words as zero.
// A stalled output holds its result; the next item is taken meanwhile.
`default_nettype none

module allpass_peak_filter
  import apf_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire apf_in_t                  in_item_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output apf_out_t                      out_item_o,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  apf_cfg_t cfg_q;
  logic     res_valid;
  logic     res_ready;
  apf_out_t res_item;
  logic     out_valid_q;
  apf_out_t out_item_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (apf_cfg_reg_e'(cfg_idx_i))
        CFG_COEF_C:  cfg_q.coef_c  <= $signed(cfg_data_i[COEF_BITS-1:0]);
        CFG_COEF_D:  cfg_q.coef_d  <= $signed(cfg_data_i[COEF_BITS-1:0]);
        CFG_GAIN_H0: cfg_q.gain_h0 <= $signed(cfg_data_i[GAIN_BITS-1:0]);
        default: ;
      endcase
    end
  end

  apf_core #(
    .CHANNELS (CHANNELS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_item_o  (res_item)
  );

  // Output register: take a result when empty or draining
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_item_q <= res_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire
